### design/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: shared definitions for the line rasterizer
// op codes, line class codes and default field widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lr_pkg;

  // default coordinate width and packed color width
  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 24;

  // input word op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // line class picked on load
  typedef enum logic [1:0] {
    MODE_SHALLOW  = 2'd0,
    MODE_STEEP_UP = 2'd1,
    MODE_STEEP_DN = 2'd2
  } mode_t;

endpackage

### design/line_rasterizer.sv
// ----------------------------------------------------------------------------
// path: a step word is held in the input register, then its pixel word in the output register
// throughput: one word per cycle while the pixel channel does not stall; the error update is one add pair per pixel
// reset: rst_n synchronous, active low, clears word valids and the active line
// line_rasterizer: midpoint line rasterizer for all octants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [COORD_BITS-1:0]        in_x_start,
  input  logic signed [COORD_BITS-1:0]        in_y_start,
  input  logic signed [COORD_BITS-1:0]        in_x_end,
  input  logic signed [COORD_BITS-1:0]        in_y_end,
  input  logic        [lr_pkg::COLOR_BITS-1:0] in_line_color,
  // pixel channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_BITS-1:0]        out_pixel_x,
  output logic signed [COORD_BITS-1:0]        out_pixel_y,
  output logic        [lr_pkg::COLOR_BITS-1:0] out_pixel_color,
  output logic                                out_last
);

  // delta width, increment width and error term width
  localparam int DW = COORD_BITS + 1;
  localparam int IW = COORD_BITS + 3;
  localparam int EW = COORD_BITS + 6;
  localparam int CB = lr_pkg::COLOR_BITS;

  // --------------------------------------------------------------------------
  // input register: one word deep, refilled in the same cycle it drains
  // --------------------------------------------------------------------------
  logic                         in_vld_r;
  logic                         op_r;
  logic signed [COORD_BITS-1:0] xs_r, ys_r, xe_r, ye_r;
  logic        [CB-1:0]         color_in_r;

  // --------------------------------------------------------------------------
  // line state
  // --------------------------------------------------------------------------
  logic                         active_r;
  lr_pkg::mode_t                mode_r;
  logic                         minor_neg_r;   // shallow lines: minor axis falls
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, stop_r;
  logic signed [EW-1:0]         err_r;
  logic signed [IW-1:0]         inc_a_r, inc_b_r;
  logic        [CB-1:0]         held_color_r;

  // output register
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic        [CB-1:0]         out_color_r;
  logic                         out_last_r;

  // handshake control
  logic emit;      // the word in the input register produces a pixel
  logic out_free;  // output register can take a pixel this cycle
  logic adv;       // input register word is consumed this cycle

  assign emit     = (op_r == lr_pkg::OP_STEP) && active_r;
  assign out_free = !out_valid_r || out_ready;
  assign adv      = in_vld_r && (out_free || !emit);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_op;
      xs_r       <= in_x_start;
      ys_r       <= in_y_start;
      xe_r       <= in_x_end;
      ye_r       <= in_y_end;
      color_in_r <= in_line_color;
    end
  end

  // --------------------------------------------------------------------------
  // load setup: order endpoints so x rises, classify the slope,
  // build the doubled error term and its increments
  // --------------------------------------------------------------------------
  logic                         swap;
  logic signed [COORD_BITS-1:0] lx0, ly0, lx1, ly1;
  logic signed [DW-1:0]         dx, dy, ady;
  logic signed [IW-1:0]         dx_i, dy_i, ady_i;
  logic signed [EW-1:0]         dx_e, dy_e, ady_e;
  logic                         shallow;
  lr_pkg::mode_t                ld_mode;
  logic signed [IW-1:0]         ld_inc_a, ld_inc_b;
  logic signed [EW-1:0]         ld_err;
  logic signed [COORD_BITS-1:0] ld_stop;

  always_comb begin
    swap = (xe_r < xs_r);
    lx0  = swap ? xe_r : xs_r;
    ly0  = swap ? ye_r : ys_r;
    lx1  = swap ? xs_r : xe_r;
    ly1  = swap ? ys_r : ye_r;

    dx   = DW'(lx1) - DW'(lx0);
    dy   = DW'(ly1) - DW'(ly0);
    ady  = dy[DW-1] ? -dy : dy;

    dx_i  = IW'(dx);
    dy_i  = IW'(dy);
    ady_i = IW'(ady);
    dx_e  = EW'(dx);
    dy_e  = EW'(dy);
    ady_e = EW'(ady);

    // equal slopes count as shallow
    shallow  = (dx >= ady);
    ld_inc_b = -(dx_i <<< 1);
    if (shallow) begin
      ld_mode  = lr_pkg::MODE_SHALLOW;
      ld_inc_a = ady_i <<< 1;
      ld_err   = (ady_e <<< 1) - dx_e;
      ld_stop  = lx1;
    end else if (!dy[DW-1]) begin
      ld_mode  = lr_pkg::MODE_STEEP_UP;
      ld_inc_a = dy_i <<< 1;
      ld_err   = dy_e - (dx_e <<< 1);
      ld_stop  = ly1;
    end else begin
      ld_mode  = lr_pkg::MODE_STEEP_DN;
      ld_inc_a = dy_i <<< 1;
      ld_err   = dy_e + (dx_e <<< 1);
      ld_stop  = ly1;
    end
  end

  // --------------------------------------------------------------------------
  // pixel step: major axis moves every pixel, minor axis on the error sign
  // --------------------------------------------------------------------------
  logic signed [EW-1:0]         inc_a_e, inc_b_e;
  logic                         err_neg, err_pos, take;
  logic signed [COORD_BITS-1:0] x_inc, y_inc, y_dec;
  logic signed [COORD_BITS-1:0] st_x, st_y;
  logic signed [EW-1:0]         st_err;
  logic                         st_last;

  always_comb begin
    inc_a_e = EW'(inc_a_r);
    inc_b_e = EW'(inc_b_r);
    err_neg = err_r[EW-1];
    err_pos = !err_r[EW-1] && (err_r != '0);
    x_inc   = cur_x_r + COORD_BITS'(1);
    y_inc   = cur_y_r + COORD_BITS'(1);
    y_dec   = cur_y_r - COORD_BITS'(1);

    case (mode_r)
      lr_pkg::MODE_STEEP_UP: begin
        take    = err_neg;
        st_last = (cur_y_r == stop_r);
        st_x    = take ? x_inc : cur_x_r;
        st_y    = y_inc;
        st_err  = err_r + (take ? inc_a_e : EW'(0)) + inc_b_e;
      end
      lr_pkg::MODE_STEEP_DN: begin
        take    = err_pos;
        st_last = (cur_y_r == stop_r);
        st_x    = take ? x_inc : cur_x_r;
        st_y    = y_dec;
        st_err  = err_r + (take ? inc_a_e : EW'(0)) - inc_b_e;
      end
      default: begin
        // shallow
        take    = err_pos;
        st_last = (cur_x_r == stop_r);
        st_x    = x_inc;
        st_y    = take ? (minor_neg_r ? y_dec : y_inc) : cur_y_r;
        st_err  = err_r + (take ? inc_b_e : EW'(0)) + inc_a_e;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // state update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      mode_r      <= lr_pkg::MODE_SHALLOW;
      minor_neg_r <= 1'b0;
    end else if (adv) begin
      if (op_r == lr_pkg::OP_LOAD) begin
        // a load drops any running line
        active_r    <= 1'b1;
        mode_r      <= ld_mode;
        minor_neg_r <= shallow && dy[DW-1];
      end else if (active_r && st_last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (op_r == lr_pkg::OP_LOAD) begin
        cur_x_r      <= lx0;
        cur_y_r      <= ly0;
        stop_r       <= ld_stop;
        err_r        <= ld_err;
        inc_a_r      <= ld_inc_a;
        inc_b_r      <= ld_inc_b;
        held_color_r <= color_in_r;
      end else if (active_r) begin
        cur_x_r <= st_x;
        cur_y_r <= st_y;
        err_r   <= st_err;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: holds a pixel word until the consumer takes it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_color_r <= held_color_r;
      out_last_r  <= st_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_last_ends_line : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit && st_last) |=> !active_r)
    else $error("line still active after its last pixel");

  a_load_starts_line : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (op_r == lr_pkg::OP_LOAD)) |=> active_r)
    else $error("load did not start a line");

  a_pixel_from_step : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && emit))
    else $error("pixel word appeared without an active step");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(adv && emit))
    else $error("pixel word overwritten while stalled");

endmodule

### dv/line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_tb: self-checking bench for the midpoint line rasterizer
// loads lines of every octant and steps them out pixel by pixel, predicting
// each pixel word in a scoreboard and comparing it with the pixel channel
// while both channels idle and stall at random
// ----------------------------------------------------------------------------

module line_rasterizer_tb;

  localparam int CB      = lr_pkg::COORD_BITS_DEF;
  localparam int CMIN    = -(1 << (CB - 1));
  localparam int CMAX    = (1 << (CB - 1)) - 1;
  localparam int PER_PHASE = 325;

  // one expected pixel word
  typedef struct packed {
    logic [CB-1:0]                 x;
    logic [CB-1:0]                 y;
    logic [lr_pkg::COLOR_BITS-1:0] color;
    logic                          last;
  } pixel_t;

  // holds its own copy of the line state and a queue of pixels still owed
  class pixel_scoreboard;
    pixel_t                        pending_q[$];
    int                            mismatches;
    bit                            busy;
    int                            px, py, end_coord, err2, step_a, step_b, y_dir;
    lr_pkg::mode_t                 line_mode;
    logic [lr_pkg::COLOR_BITS-1:0] color;

    function new();
      mismatches = 0;
      busy       = 1'b0;
      px         = 0;
      py         = 0;
      end_coord  = 0;
      err2       = 0;
      step_a     = 0;
      step_b     = 0;
      y_dir      = 1;
      line_mode  = lr_pkg::MODE_SHALLOW;
      color      = '0;
    endfunction

    // returns 1 when the word does something (load, or step of a live line)
    function bit note_word(logic op, logic signed [CB-1:0] xs, logic signed [CB-1:0] ys,
                           logic signed [CB-1:0] xe, logic signed [CB-1:0] ye,
                           logic [lr_pkg::COLOR_BITS-1:0] col);
      int     x0, y0, x1, y1, t, dx, dy, ady;
      bit     at_end;
      pixel_t pix;
      if (op == lr_pkg::OP_LOAD) begin
        x0 = xs;
        y0 = ys;
        x1 = xe;
        y1 = ye;
        // endpoints swapped so x never falls
        if (x1 < x0) begin
          t = x0; x0 = x1; x1 = t;
          t = y0; y0 = y1; y1 = t;
        end
        dx     = x1 - x0;
        dy     = y1 - y0;
        ady    = (dy < 0) ? -dy : dy;
        px     = x0;
        py     = y0;
        color  = col;
        step_b = -2 * dx;
        y_dir  = 1;
        if (dx >= ady) begin
          line_mode = lr_pkg::MODE_SHALLOW;
          if (dy < 0) y_dir = -1;
          step_a    = 2 * ady;
          err2      = 2 * ady - dx;
          end_coord = x1;
        end else if (dy >= 0) begin
          line_mode = lr_pkg::MODE_STEEP_UP;
          step_a    = 2 * dy;
          err2      = dy - 2 * dx;
          end_coord = y1;
        end else begin
          line_mode = lr_pkg::MODE_STEEP_DN;
          step_a    = 2 * dy;
          err2      = dy + 2 * dx;
          end_coord = y1;
        end
        busy = 1'b1;
        return 1'b1;
      end
      if (!busy) return 1'b0;
      pix.x     = px[CB-1:0];
      pix.y     = py[CB-1:0];
      pix.color = color;
      case (line_mode)
        lr_pkg::MODE_STEEP_UP: begin
          at_end = (py == end_coord);
          if (err2 < 0) begin
            px   += 1;
            err2 += step_a;
          end
          py   += 1;
          err2 += step_b;
        end
        lr_pkg::MODE_STEEP_DN: begin
          at_end = (py == end_coord);
          if (err2 > 0) begin
            px   += 1;
            err2 += step_a;
          end
          py   -= 1;
          err2 -= step_b;
        end
        default: begin
          at_end = (px == end_coord);
          if (err2 > 0) begin
            py   += y_dir;
            err2 += step_b;
          end
          px   += 1;
          err2 += step_a;
        end
      endcase
      pix.last = at_end;
      if (at_end) busy = 1'b0;
      pending_q.push_back(pix);
      return 1'b1;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_pixel(logic [CB-1:0] x, logic [CB-1:0] y,
                              logic [lr_pkg::COLOR_BITS-1:0] col, logic lst);
      pixel_t exp_pix;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                         $signed(x), $signed(y), col, lst));
        return;
      end
      exp_pix = pending_q.pop_front();
      if (exp_pix.x !== x || exp_pix.y !== y || exp_pix.color !== col ||
          exp_pix.last !== lst)
        report({$sformatf("pixel mismatch: expected x=%0d y=%0d color=%06h last=%0b",
                          $signed(exp_pix.x), $signed(exp_pix.y), exp_pix.color,
                          exp_pix.last),
                $sformatf(", got x=%0d y=%0d color=%06h last=%0b",
                          $signed(x), $signed(y), col, lst)});
    endfunction
  endclass

  // clock, reset and block ports
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_op = lr_pkg::OP_STEP;
  logic signed [CB-1:0]          in_x_start = '0;
  logic signed [CB-1:0]          in_y_start = '0;
  logic signed [CB-1:0]          in_x_end = '0;
  logic signed [CB-1:0]          in_y_end = '0;
  logic [lr_pkg::COLOR_BITS-1:0] in_line_color = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [CB-1:0]          out_pixel_x;
  logic signed [CB-1:0]          out_pixel_y;
  logic [lr_pkg::COLOR_BITS-1:0] out_pixel_color;
  logic                          out_last;

  // idle rates in percent, changed per phase
  int send_idle = 0;
  int recv_stall = 0;
  // words that did real work (loads and steps of a live line)
  int work_words = 0;

  pixel_scoreboard lines = new();

  line_rasterizer #(.COORD_BITS(CB)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_line_color   (in_line_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pixel sink: random back-pressure, new ready value each edge
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // every accepted pixel word goes to the scoreboard; values are pre-edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      lines.check_pixel(out_pixel_x, out_pixel_y, out_pixel_color, out_last);
  end

  // one input word: optional idle gap first, then hold valid until taken
  task automatic send_word(logic op, int xs, int ys, int xe, int ye,
                           logic [lr_pkg::COLOR_BITS-1:0] col);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_x_start    <= CB'(xs);
    in_y_start    <= CB'(ys);
    in_x_end      <= CB'(xe);
    in_y_end      <= CB'(ye);
    in_line_color <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (lines.note_word(op, CB'(xs), CB'(ys), CB'(xe), CB'(ye), col)) work_words++;
  endtask

  // step word; the coordinate and color fields are don't-care, so fill with noise
  task automatic step_line();
    send_word(lr_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom,
              lr_pkg::COLOR_BITS'($urandom));
  endtask

  function automatic int clamp_coord(int c);
    if (c < CMIN) return CMIN;
    if (c > CMAX) return CMAX;
    return c;
  endfunction

  // mostly anywhere in range, sometimes pinned to a screen border
  function automatic int pick_coord();
    int roll;
    roll = $urandom_range(15);
    if (roll == 0) return CMIN;
    if (roll == 1) return CMAX;
    return $urandom_range(0, CMAX - CMIN) + CMIN;
  endfunction

  // one line: load, then enough steps to finish it; some lines get cut
  // short by the next load, some get extra steps that land on an idle block
  task automatic draw_random_line();
    int x0, y0, x1, y1, reach, len, steps, roll;
    roll = $urandom_range(99);
    // a few single stray steps
    if (roll < 5) begin
      step_line();
      return;
    end
    x0 = pick_coord();
    y0 = pick_coord();
    reach = (roll < 9) ? (CMAX - CMIN) : $urandom_range(0, 12);
    x1 = clamp_coord(x0 + $urandom_range(0, 2 * reach) - reach);
    y1 = clamp_coord(y0 + $urandom_range(0, 2 * reach) - reach);
    len = ((x1 > x0) ? x1 - x0 : x0 - x1);
    if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) len = (y1 > y0) ? y1 - y0 : y0 - y1;
    len = len + 1;
    if (len > 40) steps = $urandom_range(0, 20);
    else if ($urandom_range(99) < 10) steps = $urandom_range(0, len - 1);
    else if ($urandom_range(99) < 15) steps = len + $urandom_range(1, 2);
    else steps = len;
    send_word(lr_pkg::OP_LOAD, x0, y0, x1, y1, lr_pkg::COLOR_BITS'($urandom));
    repeat (steps) step_line();
  endtask

  // hard stop if the handshakes hang
  initial begin
    #5_000_000;
    $display("FAIL line_rasterizer");
    $finish;
  end

  initial begin
    int drain;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: step with no line loaded gives nothing
    step_line();
    // single point line, then a step after it ends
    send_word(lr_pkg::OP_LOAD, 5, -7, 5, -7, 24'h123456);
    step_line();
    step_line();
    // equal slopes, falling y, endpoints given right to left
    send_word(lr_pkg::OP_LOAD, 2, -1, -1, 2, 24'hA5A5A5);
    repeat (4) step_line();
    // steep rising
    send_word(lr_pkg::OP_LOAD, 0, 0, 1, 3, 24'h5A5A5A);
    repeat (4) step_line();
    // steep falling at the top-left corner
    send_word(lr_pkg::OP_LOAD, CMIN, CMAX, CMIN + 1, CMAX - 4, 24'h00FF00);
    repeat (5) step_line();
    // full-screen diagonals, the first dropped by a new load while running
    send_word(lr_pkg::OP_LOAD, CMIN, CMIN, CMAX, CMAX, 24'hFFFFFF);
    repeat (2) step_line();
    send_word(lr_pkg::OP_LOAD, CMAX, CMIN, CMIN, CMAX, 24'h000000);
    repeat (2) step_line();

    // random phases: no idling, sender idle, sink stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 46; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 46; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      work_words = 0;
      while (work_words < PER_PHASE) draw_random_line();
    end
    in_valid <= 1'b0;

    // wait for owed pixels, then keep clocking to catch anything stray
    drain = 0;
    while (lines.pending_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);

    if (lines.mismatches == 0 && lines.pending_q.size() == 0) begin
      $display("PASS line_rasterizer");
    end else begin
      $display("FAIL line_rasterizer");
    end
    $finish;
  end

endmodule
